// ===== design/stta_pkg.sv =====
`timescale 1ns / 1ps

package stta_pkg;

  localparam int unsigned RAW_W     = 32;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned DELTA_W   = 40;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned PROD_W    = RAW_W + RATE_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam int unsigned RATE_FRAC_BITS = 24;

  localparam logic [RATE_W-1:0]   TIME_RATE_RST  = 32'd16777216;
  localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 32'd1000000000;
  localparam logic [DELTA_W-1:0]  DELTA_MAX      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_FROZEN = 2'd0,
    CFG_TIME_RATE   = 2'd1,
    CFG_TICK_PERIOD = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_ADVANCE = 1'b0,
    MODE_CLEAR   = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_MUL,
    ST_SCALE,
    ST_DIST,
    ST_CMP,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                start;
    logic [TIME_W-1:0]   dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [TIME_W-1:0]   quotient;
    logic [PERIOD_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/stta_if.sv =====
`timescale 1ns / 1ps

interface stta_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [stta_pkg::RAW_W-1:0] raw_delta_ns;

  modport source (output valid, output mode, output raw_delta_ns, input ready);
  modport sink   (input valid, input mode, input raw_delta_ns, output ready);
endinterface

interface stta_out_if;
  logic                         valid;
  logic                         ready;
  logic [stta_pkg::DELTA_W-1:0] scaled_delta_ns;
  logic [stta_pkg::TIME_W-1:0]  elapsed_ns;
  logic [stta_pkg::DELTA_W-1:0] ticks_this_step;
  logic [stta_pkg::TIME_W-1:0]  total_ticks;

  modport source (output valid, output scaled_delta_ns, output elapsed_ns,
                  output ticks_this_step, output total_ticks, input ready);
  modport sink   (input valid, input scaled_delta_ns, input elapsed_ns,
                  input ticks_this_step, input total_ticks, output ready);
endinterface

// ===== design/stta_div.sv =====
`timescale 1ns / 1ps

module stta_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stta_pkg::div_req_t req_i,
  output stta_pkg::div_rsp_t rsp_o
);
  import stta_pkg::*;

  localparam int unsigned CntW = $clog2(TIME_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [TIME_W-1:0]   dvd_q, dvd_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [PERIOD_W-1:0] dsr_q, dsr_d;

  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W+1:0] diff;
  logic                fits;

  // One restoring step per cycle: the dividend shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    trial  = {rem_q, dvd_q[TIME_W-1]};
    diff   = {1'b0, trial} - {2'b00, dsr_q};
    fits   = ~diff[PERIOD_W+1];
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TIME_W-2:0], fits};
      rem_d = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(TIME_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== design/scaled_time_tick_accumulator.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Word
// -------  ---  ------------  ---------------------------------------------------
// in_i     in   valid/ready   mode, raw_delta_ns
// out_o    out  valid/ready   scaled_delta_ns, elapsed_ns, ticks_this_step,
//                             total_ticks
// cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i (no back-pressure)
//
// An advance that needs a division waits on the radix-2 divider, which takes
// one quotient bit per cycle over 64 bits. Clears go from ST_CLR to ST_OUT,
// and advances that produce no tick go from ST_CMP to ST_UPD without the divider.
// One word is in flight at a time; in_i.ready is high only when idle.
// A finished word waits in the output register while the next word is taken.
// Reset restores the register defaults and zeroes the time and tick counters.

module scaled_time_tick_accumulator #(
  parameter int unsigned RateFracBits = stta_pkg::RATE_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  stta_in_if.sink                          in_i,
  stta_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [stta_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stta_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import stta_pkg::*;

  state_e state_q, state_d;

  logic                frozen_q;
  logic [RATE_W-1:0]   rate_q;
  logic [PERIOD_W-1:0] period_q;

  logic [RAW_W-1:0]    raw_q, raw_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [DELTA_W-1:0]  scaled_q, scaled_d;
  logic [TIME_W-1:0]   elapsed_q, elapsed_d;
  logic [TIME_W-1:0]   last_q, last_d;
  logic [TIME_W-1:0]   total_q, total_d;
  logic [TIME_W-1:0]   dist_q, dist_d;
  logic [TIME_W-1:0]   dm1_q, dm1_d;
  logic [TIME_W-1:0]   step_q, step_d;
  logic [TIME_W-1:0]   nfull_q, nfull_d;

  logic                out_valid_q, out_valid_d;
  logic [DELTA_W-1:0]  out_scaled_q, out_scaled_d;
  logic [TIME_W-1:0]   out_elapsed_q, out_elapsed_d;
  logic [DELTA_W-1:0]  out_ticks_q, out_ticks_d;
  logic [TIME_W-1:0]   out_total_q, out_total_d;

  logic [PROD_W-1:0]   shifted;
  logic                in_fire;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_fire = in_i.valid && in_i.ready;
  assign shifted = prod_q >> RateFracBits;

  // Configuration; a zero period is stored as one second.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frozen_q <= 1'b0;
      rate_q   <= TIME_RATE_RST;
      period_q <= PERIOD_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_FROZEN: frozen_q <= cfg_wdata_i[0];
        CFG_TIME_RATE:   rate_q   <= cfg_wdata_i[RATE_W-1:0];
        CFG_TICK_PERIOD: begin
          period_q <= (cfg_wdata_i[PERIOD_W-1:0] == '0) ? PERIOD_DEFAULT
                                                        : cfg_wdata_i[PERIOD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d       = state_q;
    raw_d         = raw_q;
    prod_d        = prod_q;
    scaled_d      = scaled_q;
    elapsed_d     = elapsed_q;
    last_d        = last_q;
    total_d       = total_q;
    dist_d        = dist_q;
    dm1_d         = dm1_q;
    step_d        = step_q;
    nfull_d       = nfull_q;
    out_valid_d   = out_valid_q;
    out_scaled_d  = out_scaled_q;
    out_elapsed_d = out_elapsed_q;
    out_ticks_d   = out_ticks_q;
    out_total_d   = out_total_q;
    div_req.start    = 1'b0;
    div_req.dividend = dist_q - TIME_W'(1);
    div_req.divisor  = period_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          raw_d   = in_i.raw_delta_ns;
          state_d = (in_i.mode == MODE_CLEAR) ? ST_CLR : ST_MUL;
        end
      end
      ST_CLR: begin
        elapsed_d = '0;
        last_d    = '0;
        total_d   = '0;
        scaled_d  = '0;
        nfull_d   = '0;
        state_d   = ST_OUT;
      end
      ST_MUL: begin
        prod_d  = frozen_q ? '0 : PROD_W'(raw_q) * PROD_W'(rate_q);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        scaled_d  = (|shifted[PROD_W-1:DELTA_W]) ? DELTA_MAX : shifted[DELTA_W-1:0];
        elapsed_d = elapsed_q + TIME_W'(scaled_d);
        state_d   = ST_DIST;
      end
      ST_DIST: begin
        // The distance wraps modulo the counter width, as elapsed time does.
        dist_d  = elapsed_q - last_q;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        dm1_d = dist_q - TIME_W'(1);
        if (dist_q > TIME_W'(period_q)) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          step_d  = '0;
          nfull_d = '0;
          state_d = ST_UPD;
        end
      end
      ST_DIV: begin
        // Whole periods covered equal the dividend less its remainder.
        if (div_rsp.done) begin
          nfull_d = div_rsp.quotient;
          step_d  = dm1_q - TIME_W'(div_rsp.remainder);
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        last_d  = last_q + step_q;
        total_d = total_q + nfull_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_scaled_d  = scaled_q;
          out_elapsed_d = elapsed_q;
          out_ticks_d   = (|nfull_q[TIME_W-1:DELTA_W]) ? DELTA_MAX
                                                       : nfull_q[DELTA_W-1:0];
          out_total_d   = total_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      elapsed_q   <= '0;
      last_q      <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      elapsed_q   <= elapsed_d;
      last_q      <= last_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q         <= raw_d;
    prod_q        <= prod_d;
    scaled_q      <= scaled_d;
    dist_q        <= dist_d;
    dm1_q         <= dm1_d;
    step_q        <= step_d;
    nfull_q       <= nfull_d;
    out_scaled_q  <= out_scaled_d;
    out_elapsed_q <= out_elapsed_d;
    out_ticks_q   <= out_ticks_d;
    out_total_q   <= out_total_d;
  end

  stta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.scaled_delta_ns = out_scaled_q;
  assign out_o.elapsed_ns      = out_elapsed_q;
  assign out_o.ticks_this_step = out_ticks_q;
  assign out_o.total_ticks     = out_total_q;

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MUL || state_q == ST_CLR))
    else $error("accepted word did not start processing");

  a_div_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_rsp.done) |=> state_q == ST_UPD)
    else $error("divider result not consumed");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_rsp.done) |-> div_rsp.remainder < period_q)
    else $error("divider remainder not below the period");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLR |=> (elapsed_q == '0 && last_q == '0 && total_q == '0))
    else $error("clear left counters non-zero");

endmodule
